>>> sv/ata_task_file_registers_defines.svh
// assertion macros shared by the checker of the task file register block
// no dependencies; taken in by `include where assertions are written
`ifndef ATA_TASK_FILE_REGISTERS_DEFINES_SVH
`define ATA_TASK_FILE_REGISTERS_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define ATF_ASSERT_NOW(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define ATF_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/atf_pkg.sv
// types, codes and constants of the ata task file register block
// no dependencies; used by the interfaces and every module
`default_nettype none

package atf_pkg;

  // drive count and config register list
  localparam int NUM_DRIVES = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int KIND_W = 2;

  // drive kinds
  localparam logic [KIND_W-1:0] KIND_DISK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CDROM = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd2;

  // access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // port decode
  localparam logic [15:0] MASK_TF    = 16'hfff8;
  localparam logic [15:0] MASK_CTL   = 16'hfffe;
  localparam logic [15:0] MASK_DMA   = 16'hfff0;
  localparam logic [15:0] BASE_PRI   = 16'h01f0;
  localparam logic [15:0] BASE_SEC   = 16'h0170;
  localparam logic [15:0] CTL_PRI    = 16'h03f6;
  localparam logic [15:0] CTL_SEC    = 16'h0376;
  localparam logic [15:0] BASE_DMA   = 16'hc000;

  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_TF   = 2'd1,
    CLS_DMA  = 2'd2
  } cls_t;

  // task file register selects
  localparam logic [3:0] TF_DATA  = 4'd0;
  localparam logic [3:0] TF_FEAT  = 4'd1;
  localparam logic [3:0] TF_SCNT  = 4'd2;
  localparam logic [3:0] TF_SNUM  = 4'd3;
  localparam logic [3:0] TF_CYLL  = 4'd4;
  localparam logic [3:0] TF_CYLH  = 4'd5;
  localparam logic [3:0] TF_DRVHD = 4'd6;
  localparam logic [3:0] TF_CMD   = 4'd7;
  localparam logic [3:0] TF_CTRL  = 4'd8;
  localparam logic [3:0] TF_ADDR  = 4'd9;

  // bus-master register selects
  localparam logic [2:0] DMA_CMD  = 3'd0;
  localparam logic [2:0] DMA_RSV1 = 3'd1;
  localparam logic [2:0] DMA_STAT = 3'd2;
  localparam logic [2:0] DMA_RSV3 = 3'd3;

  typedef enum logic [1:0] {
    OUT_OK     = 2'd0,
    OUT_BAD    = 2'd1,
    OUT_UNIMPL = 2'd2
  } outcome_t;

  // commands
  localparam logic [7:0] CMD_PACKET   = 8'ha0;
  localparam logic [7:0] CMD_ID_PKT   = 8'ha1;
  localparam logic [7:0] CMD_IDENTIFY = 8'hec;

  // bit positions
  localparam int DEV_BIT  = 4;
  localparam int NIEN_BIT = 1;
  localparam int SRST_BIT = 2;

  // register values
  localparam logic [7:0] STAT_SRST      = 8'h90;
  localparam logic [7:0] STAT_ABORT     = 8'h41;
  localparam logic [7:0] STAT_ID_PKT    = 8'h58;
  localparam logic [7:0] STAT_BSY_DF_ERR = 8'ha1;
  localparam logic [7:0] STAT_DRQ       = 8'h08;
  localparam logic [7:0] STAT_DRDY      = 8'h40;
  localparam logic [7:0] STAT_NOT_BSY   = 8'h7f;
  localparam logic [7:0] STAT_ERR       = 8'h01;
  localparam logic [7:0] ERR_ABORT      = 8'h04;
  localparam logic [7:0] ERR_DIAG_OK    = 8'h01;
  localparam logic [7:0] DRVHD_FIXED    = 8'ha0;
  localparam logic [7:0] DRVHD_NO_HEAD  = 8'hf0;
  localparam logic [7:0] CTRL_RESET     = 8'h08;
  localparam logic [7:0] ADDR_READ      = 8'hff;
  localparam logic [7:0] SECT_RESET     = 8'h01;
  localparam logic [15:0] CYL_ATAPI_SIG = 16'heb14;

  typedef struct packed {
    logic        op;
    logic [15:0] port_addr;
    logic [2:0]  access_len;
    logic [7:0]  write_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic [1:0] outcome;
    logic       irq_pulse;
    logic       irq_chan;
  } rsp_t;

  typedef struct packed {
    cls_t       cls;
    logic       ch;
    logic [3:0] rsel;
  } dec_t;

  typedef struct packed {
    logic                   en;
    logic [CFG_INDEX_W-1:0] index;
    logic [KIND_W-1:0]      data;
  } cfg_wr_t;

endpackage

`default_nettype wire

>>> sv/atf_ifs.sv
// request, response and config channel interfaces of the task file block
// depends on atf_pkg for the field widths
`default_nettype none

interface atf_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] port_addr;
  logic [2:0]  access_len;
  logic [7:0]  write_byte;

  modport source (output valid, op, port_addr, access_len, write_byte, input ready);
  modport sink (input valid, op, port_addr, access_len, write_byte, output ready);
endinterface

interface atf_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic [1:0] outcome;
  logic       irq_pulse;
  logic       irq_chan;

  modport source (output valid, read_byte, outcome, irq_pulse, irq_chan, input ready);
  modport sink (input valid, read_byte, outcome, irq_pulse, irq_chan, output ready);
endinterface

interface atf_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [atf_pkg::CFG_INDEX_W-1:0]      index;
  logic [atf_pkg::KIND_W-1:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/ata_task_file_registers.sv
// Two-channel IDE task file register block, two drives per channel. Each request is one
// byte-wide port access; it is held in the input register, is decoded and applied to the
// register state, and its response is loaded into the output register when it leaves the
// input register. One request is taken every cycle while responses are taken as they come;
// when a response stalls on the output, the request behind it waits in the input register
// and the input is held until the stall clears. The limit is the combinational
// read-modify-write of the register state in atf_regfile. The drive kinds are written
// through the config channel (index 0 to 3: primary master, primary slave, secondary
// master, secondary slave; 0 disk, 1 cdrom, 2 or 3 none); the user must write them only
// while no request is in flight, as the block itself does not enforce this.
// top level; depends on atf_pkg, atf_ifs, atf_decode and atf_regfile
`default_nettype none

module ata_task_file_registers (
  input  wire logic   clk,
  input  wire logic   rst,
  atf_req_if.sink     req,
  atf_rsp_if.source   rsp,
  atf_cfg_if.sink     cfg
);

  logic              in_valid;
  atf_pkg::req_t     in_req;
  logic              out_valid;
  atf_pkg::rsp_t     out_rsp;
  logic              advance;
  atf_pkg::dec_t     dec;
  atf_pkg::rsp_t     result;
  atf_pkg::cfg_wr_t  cfg_wr;

  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;
  assign cfg.ready = 1'b1;

  assign cfg_wr.en    = cfg.valid;
  assign cfg_wr.index = cfg.index;
  assign cfg_wr.data  = cfg.data;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_req.op         <= req.op;
      in_req.port_addr  <= req.port_addr;
      in_req.access_len <= req.access_len;
      in_req.write_byte <= req.write_byte;
    end
  end

  atf_decode u_decode (
    .port_addr (in_req.port_addr),
    .dec       (dec)
  );

  atf_regfile u_regfile (
    .clk    (clk),
    .rst    (rst),
    .commit (advance),
    .req    (in_req),
    .dec    (dec),
    .cfg_wr (cfg_wr),
    .result (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rsp <= result;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_byte = out_rsp.read_byte;
  assign rsp.outcome   = out_rsp.outcome;
  assign rsp.irq_pulse = out_rsp.irq_pulse;
  assign rsp.irq_chan  = out_rsp.irq_chan;

endmodule

`default_nettype wire

>>> sv/atf_decode.sv
// port address decode: channel, register class and register select
// depends on atf_pkg
`default_nettype none

module atf_decode (
  input  wire logic [15:0]   port_addr,
  output atf_pkg::dec_t      dec
);

  always_comb begin
    dec.cls  = atf_pkg::CLS_NONE;
    dec.ch   = 1'b0;
    dec.rsel = atf_pkg::TF_DATA;
    // command block ports
    if ((port_addr & atf_pkg::MASK_TF) == atf_pkg::BASE_PRI) begin
      dec.cls  = atf_pkg::CLS_TF;
      dec.rsel = {1'b0, port_addr[2:0]};
    end else if ((port_addr & atf_pkg::MASK_TF) == atf_pkg::BASE_SEC) begin
      dec.cls  = atf_pkg::CLS_TF;
      dec.ch   = 1'b1;
      dec.rsel = {1'b0, port_addr[2:0]};
    // control block ports
    end else if ((port_addr & atf_pkg::MASK_CTL) == atf_pkg::CTL_PRI) begin
      dec.cls  = atf_pkg::CLS_TF;
      dec.rsel = {3'b100, port_addr[0]};
    end else if ((port_addr & atf_pkg::MASK_CTL) == atf_pkg::CTL_SEC) begin
      dec.cls  = atf_pkg::CLS_TF;
      dec.ch   = 1'b1;
      dec.rsel = {3'b100, port_addr[0]};
    // bus-master block, eight bytes per channel
    end else if ((port_addr & atf_pkg::MASK_DMA) == atf_pkg::BASE_DMA) begin
      dec.cls  = atf_pkg::CLS_DMA;
      dec.ch   = port_addr[3];
      dec.rsel = {1'b0, port_addr[2:0]};
    end
  end

endmodule

`default_nettype wire

>>> sv/atf_regfile.sv
// task file, control and bus-master register state with its access logic
// depends on atf_pkg; the request is decoded by atf_decode
`default_nettype none

module atf_regfile (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             commit,
  input  atf_pkg::req_t         req,
  input  atf_pkg::dec_t         dec,
  input  atf_pkg::cfg_wr_t      cfg_wr,
  output atf_pkg::rsp_t         result
);

  // per-channel registers
  logic [7:0]  err_reg[2], feat_reg[2], drvhead_reg[2], stat_reg[2];
  logic [7:0]  command_reg[2], control_reg[2];
  logic [7:0]  err_next[2], feat_next[2], drvhead_next[2], stat_next[2];
  logic [7:0]  command_next[2], control_next[2];
  // per-drive registers
  logic [atf_pkg::KIND_W-1:0] type_reg[atf_pkg::NUM_DRIVES];
  logic [7:0]  sect_count[atf_pkg::NUM_DRIVES], sect_number[atf_pkg::NUM_DRIVES];
  logic [15:0] cyl_word[atf_pkg::NUM_DRIVES];
  logic [7:0]  dma_command[atf_pkg::NUM_DRIVES], dma_stat[atf_pkg::NUM_DRIVES];
  logic [31:0] prd_address[atf_pkg::NUM_DRIVES];
  logic [7:0]  sect_count_next[atf_pkg::NUM_DRIVES], sect_number_next[atf_pkg::NUM_DRIVES];
  logic [15:0] cyl_word_next[atf_pkg::NUM_DRIVES];
  logic [7:0]  dma_command_next[atf_pkg::NUM_DRIVES], dma_stat_next[atf_pkg::NUM_DRIVES];
  logic [31:0] prd_address_next[atf_pkg::NUM_DRIVES];

  logic                 ch;
  logic [1:0]           drv;
  logic [1:0]           drv_new;
  logic [1:0]           drv_m;
  logic [1:0]           drv_s;
  logic [2:0]           dsel;
  logic [7:0]           wb;
  logic [7:0]           rb;
  logic [7:0]           stat_tmp;
  logic                 irq_ok;
  logic                 irq;
  atf_pkg::outcome_t    outcome;

  assign ch      = dec.ch;
  assign drv     = {ch, drvhead_reg[ch][atf_pkg::DEV_BIT]};
  assign drv_new = {ch, req.write_byte[atf_pkg::DEV_BIT]};
  assign drv_m   = {ch, 1'b0};
  assign drv_s   = {ch, 1'b1};
  assign dsel    = dec.rsel[2:0];
  assign wb      = req.write_byte;
  assign irq_ok  = !control_reg[ch][atf_pkg::NIEN_BIT];

  // access: result and next register values
  always_comb begin
    err_next         = err_reg;
    feat_next        = feat_reg;
    drvhead_next     = drvhead_reg;
    stat_next        = stat_reg;
    command_next     = command_reg;
    control_next     = control_reg;
    sect_count_next  = sect_count;
    sect_number_next = sect_number;
    cyl_word_next    = cyl_word;
    dma_command_next = dma_command;
    dma_stat_next    = dma_stat;
    prd_address_next = prd_address;
    rb       = 8'h00;
    irq      = 1'b0;
    outcome  = atf_pkg::OUT_OK;
    stat_tmp = stat_reg[ch];

    if (dec.cls == atf_pkg::CLS_NONE) begin
      outcome = atf_pkg::OUT_BAD;
    end else if (dec.cls == atf_pkg::CLS_TF && dec.rsel == atf_pkg::TF_DATA) begin
      outcome = atf_pkg::OUT_UNIMPL;
    end else if (req.access_len != 3'd1) begin
      outcome = atf_pkg::OUT_BAD;
    end else if (dec.cls == atf_pkg::CLS_DMA) begin
      // bus-master bytes of the selected drive
      case (dsel)
        atf_pkg::DMA_RSV1, atf_pkg::DMA_RSV3: outcome = atf_pkg::OUT_BAD;
        atf_pkg::DMA_CMD: begin
          if (req.op == atf_pkg::OP_WRITE) dma_command_next[drv] = wb;
          else rb = dma_command[drv];
        end
        atf_pkg::DMA_STAT: begin
          if (req.op == atf_pkg::OP_WRITE) dma_stat_next[drv] = wb;
          else rb = dma_stat[drv];
        end
        default: begin
          if (req.op == atf_pkg::OP_WRITE) prd_address_next[drv][{dsel[1:0], 3'b000} +: 8] = wb;
          else rb = prd_address[drv][{dsel[1:0], 3'b000} +: 8];
        end
      endcase
    end else if (req.op == atf_pkg::OP_WRITE) begin
      // task file writes
      case (dec.rsel)
        atf_pkg::TF_FEAT: feat_next[ch] = wb;
        atf_pkg::TF_SCNT: sect_count_next[drv] = wb;
        atf_pkg::TF_SNUM: sect_number_next[drv] = wb;
        atf_pkg::TF_CYLL: cyl_word_next[drv][7:0] = wb;
        atf_pkg::TF_CYLH: cyl_word_next[drv][15:8] = wb;
        atf_pkg::TF_DRVHD: begin
          drvhead_next[ch] = wb | atf_pkg::DRVHD_FIXED;
          if (type_reg[drv_new] > atf_pkg::KIND_CDROM) begin
            err_next[ch]  = err_reg[ch] | atf_pkg::ERR_ABORT;
            stat_next[ch] = stat_reg[ch] | atf_pkg::STAT_ERR;
          end
        end
        atf_pkg::TF_CMD: begin
          command_next[ch] = wb;
          if (wb == atf_pkg::CMD_PACKET) begin
            if (type_reg[drv] != atf_pkg::KIND_CDROM) begin
              stat_tmp     = atf_pkg::STAT_ABORT;
              err_next[ch] = atf_pkg::ERR_ABORT;
              irq          = irq_ok;
            end
            sect_count_next[drv] = atf_pkg::SECT_RESET;
            stat_next[ch] = (stat_tmp & ~atf_pkg::STAT_BSY_DF_ERR) | atf_pkg::STAT_DRQ;
          end else if (wb == atf_pkg::CMD_ID_PKT) begin
            err_next[ch]  = 8'h00;
            stat_next[ch] = atf_pkg::STAT_ID_PKT;
            irq           = irq_ok;
          end else if (wb == atf_pkg::CMD_IDENTIFY) begin
            if (type_reg[drv] != atf_pkg::KIND_DISK) begin
              sect_count_next[drv]  = atf_pkg::SECT_RESET;
              sect_number_next[drv] = atf_pkg::SECT_RESET;
              cyl_word_next[drv]    = (type_reg[drv] == atf_pkg::KIND_CDROM) ?
                                      atf_pkg::CYL_ATAPI_SIG : 16'h0000;
              stat_next[ch] = atf_pkg::STAT_ABORT;
              err_next[ch]  = atf_pkg::ERR_ABORT;
              irq           = irq_ok;
            end else begin
              outcome = atf_pkg::OUT_UNIMPL;
            end
          end else begin
            outcome = atf_pkg::OUT_UNIMPL;
          end
        end
        atf_pkg::TF_CTRL: begin
          // soft reset on either edge of srst
          if (!control_reg[ch][atf_pkg::SRST_BIT] && wb[atf_pkg::SRST_BIT]) begin
            stat_next[ch]    = atf_pkg::STAT_SRST;
            err_next[ch]     = atf_pkg::ERR_DIAG_OK;
            command_next[ch] = 8'h00;
          end else if (control_reg[ch][atf_pkg::SRST_BIT] && !wb[atf_pkg::SRST_BIT]) begin
            stat_next[ch]    = (stat_reg[ch] & atf_pkg::STAT_NOT_BSY) | atf_pkg::STAT_DRDY;
            drvhead_next[ch] = drvhead_reg[ch] & atf_pkg::DRVHD_NO_HEAD;
            sect_count_next[drv_m]  = atf_pkg::SECT_RESET;
            sect_number_next[drv_m] = atf_pkg::SECT_RESET;
            cyl_word_next[drv_m]    = (type_reg[drv_m] == atf_pkg::KIND_CDROM) ?
                                      atf_pkg::CYL_ATAPI_SIG : 16'h0000;
            sect_count_next[drv_s]  = atf_pkg::SECT_RESET;
            sect_number_next[drv_s] = atf_pkg::SECT_RESET;
            cyl_word_next[drv_s]    = (type_reg[drv_s] == atf_pkg::KIND_CDROM) ?
                                      atf_pkg::CYL_ATAPI_SIG : 16'h0000;
          end
          control_next[ch] = wb;
        end
        default: outcome = atf_pkg::OUT_BAD;
      endcase
    end else begin
      // task file reads; an absent drive floats to zero but for drive/head, which reads a0
      if (dec.rsel == atf_pkg::TF_ADDR) begin
        rb = atf_pkg::ADDR_READ;
      end else if (type_reg[drv] > atf_pkg::KIND_CDROM) begin
        rb = (dec.rsel == atf_pkg::TF_DRVHD) ? atf_pkg::DRVHD_FIXED : 8'h00;
      end else begin
        case (dec.rsel)
          atf_pkg::TF_FEAT:  rb = err_reg[ch];
          atf_pkg::TF_SCNT:  rb = sect_count[drv];
          atf_pkg::TF_SNUM:  rb = sect_number[drv];
          atf_pkg::TF_CYLL:  rb = cyl_word[drv][7:0];
          atf_pkg::TF_CYLH:  rb = cyl_word[drv][15:8];
          atf_pkg::TF_DRVHD: rb = drvhead_reg[ch];
          default:           rb = stat_reg[ch];
        endcase
      end
    end

    result.read_byte = (req.op == atf_pkg::OP_WRITE) ? 8'h00 : rb;
    result.outcome   = outcome;
    result.irq_pulse = irq;
    result.irq_chan  = irq & ch;
  end

  // register update on commit, drive kinds on config write
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        err_reg[i]     <= atf_pkg::ERR_DIAG_OK;
        feat_reg[i]    <= 8'h00;
        drvhead_reg[i] <= 8'h00;
        stat_reg[i]    <= 8'h00;
        command_reg[i] <= 8'h00;
        control_reg[i] <= atf_pkg::CTRL_RESET;
      end
      for (int i = 0; i < atf_pkg::NUM_DRIVES; i++) begin
        type_reg[i]    <= atf_pkg::KIND_NONE;
        sect_count[i]  <= atf_pkg::SECT_RESET;
        sect_number[i] <= atf_pkg::SECT_RESET;
        cyl_word[i]    <= 16'h0000;
        dma_command[i] <= 8'h00;
        dma_stat[i]    <= 8'h00;
        prd_address[i] <= 32'h0000_0000;
      end
    end else begin
      if (commit) begin
        err_reg     <= err_next;
        feat_reg    <= feat_next;
        drvhead_reg <= drvhead_next;
        stat_reg    <= stat_next;
        command_reg <= command_next;
        control_reg <= control_next;
        sect_count  <= sect_count_next;
        sect_number <= sect_number_next;
        cyl_word    <= cyl_word_next;
        dma_command <= dma_command_next;
        dma_stat    <= dma_stat_next;
        prd_address <= prd_address_next;
      end
      if (cfg_wr.en && cfg_wr.index < atf_pkg::CFG_INDEX_W'(atf_pkg::NUM_DRIVES)) begin
        type_reg[cfg_wr.index[1:0]] <= cfg_wr.data;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/atf_checker.sv
// port-level checks of the task file register block, bound to the top level
// depends on atf_pkg and ata_task_file_registers_defines.svh
`default_nettype none
`include "ata_task_file_registers_defines.svh"

module atf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic [7:0] rsp_read_byte,
  input wire logic [1:0] rsp_outcome,
  input wire logic       rsp_irq_pulse,
  input wire logic       rsp_irq_chan
);

  // a stalled response holds
  `ATF_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_byte) && $stable(rsp_outcome) && $stable(rsp_irq_pulse) && $stable(rsp_irq_chan), "stalled response changed")

  // interrupts only come with requests whose outcome is OK
  `ATF_ASSERT_NOW(a_irq_ok, clk, rst, rsp_valid && rsp_irq_pulse, rsp_outcome == atf_pkg::OUT_OK, "interrupt on a failed request")

  // channel field is quiet without an interrupt
  `ATF_ASSERT_NOW(a_irq_chan, clk, rst, rsp_valid && !rsp_irq_pulse, !rsp_irq_chan, "interrupt channel without interrupt")

  // no outcome code beyond the defined ones
  `ATF_ASSERT_NOW(a_outcome, clk, rst, rsp_valid, rsp_outcome != 2'd3, "undefined outcome code")

  // reset empties the output register
  `ATF_ASSERT_NEXT(a_rst_empty, clk, 1'b0, rst, !rsp_valid, "response valid after reset")

endmodule

bind ata_task_file_registers atf_checker u_atf_checker (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_read_byte (rsp.read_byte),
  .rsp_outcome   (rsp.outcome),
  .rsp_irq_pulse (rsp.irq_pulse),
  .rsp_irq_chan  (rsp.irq_chan)
);

`default_nettype wire

>>> tb/tb_ata_task_file_registers.sv
// self-checking testbench of the two-channel ata task file register block
// depends on atf_pkg, atf_ifs and the ata_task_file_registers top level
`timescale 1ns / 100ps

module tb_ata_task_file_registers;
  import atf_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int NUM_PHASES = 6;

  // shadow copy of the register block, predicts one reply per request
  class task_file_shadow;
    logic [KIND_W-1:0] kind[NUM_DRIVES];
    logic [7:0] err[2], drvhd[2], stat[2], ctrl[2];
    logic [7:0] scnt[NUM_DRIVES], snum[NUM_DRIVES];
    logic [7:0] dcmd[NUM_DRIVES], dstat[NUM_DRIVES];
    logic [15:0] cyl[NUM_DRIVES];
    logic [31:0] prd[NUM_DRIVES];
    rsp_t expected_replies[$];
    int mismatches;

    // feature and command registers cannot be read back, so they are not tracked
    function new();
      for (int i = 0; i < NUM_DRIVES; i++) begin
        kind[i] = KIND_NONE;
        scnt[i] = SECT_RESET;
        snum[i] = SECT_RESET;
        cyl[i] = '0;
        dcmd[i] = '0;
        dstat[i] = '0;
        prd[i] = '0;
      end
      for (int i = 0; i < 2; i++) begin
        err[i] = ERR_DIAG_OK;
        drvhd[i] = '0;
        stat[i] = '0;
        ctrl[i] = CTRL_RESET;
      end
      mismatches = 0;
    endfunction

    function void set_kind(int idx, logic [KIND_W-1:0] v);
      kind[idx] = v;
    endfunction

    function logic [1:0] sel_drive(logic ch);
      return {ch, drvhd[ch][DEV_BIT]};
    endfunction

    // kind 3 counts as no drive as well
    function bit absent(logic [1:0] d);
      return kind[d] > KIND_CDROM;
    endfunction

    function void reset_drive(logic [1:0] d);
      scnt[d] = SECT_RESET;
      snum[d] = SECT_RESET;
      cyl[d] = (kind[d] == KIND_CDROM) ? CYL_ATAPI_SIG : 16'h0000;
    endfunction

    function logic abort_cmd(logic ch);
      stat[ch] = STAT_ABORT;
      err[ch] = ERR_ABORT;
      return !ctrl[ch][NIEN_BIT];
    endfunction

    function void note_access(req_t r);
      cls_t cls;
      logic ch;
      logic [3:0] rsel;
      logic [1:0] d;
      outcome_t oc;
      logic [7:0] rb;
      logic [7:0] wb;
      logic irq;
      rsp_t e;
      cls = CLS_NONE;
      ch = 1'b0;
      rsel = '0;
      oc = OUT_OK;
      rb = '0;
      irq = 1'b0;
      wb = r.write_byte;

      // port decode
      if ((r.port_addr & MASK_TF) == BASE_PRI) begin
        cls = CLS_TF;
        rsel = {1'b0, r.port_addr[2:0]};
      end else if ((r.port_addr & MASK_TF) == BASE_SEC) begin
        cls = CLS_TF;
        ch = 1'b1;
        rsel = {1'b0, r.port_addr[2:0]};
      end else if ((r.port_addr & MASK_CTL) == CTL_PRI) begin
        cls = CLS_TF;
        rsel = r.port_addr[0] ? TF_ADDR : TF_CTRL;
      end else if ((r.port_addr & MASK_CTL) == CTL_SEC) begin
        cls = CLS_TF;
        ch = 1'b1;
        rsel = r.port_addr[0] ? TF_ADDR : TF_CTRL;
      end else if ((r.port_addr & MASK_DMA) == BASE_DMA) begin
        cls = CLS_DMA;
        ch = r.port_addr[3];
        rsel = {1'b0, r.port_addr[2:0]};
      end
      d = sel_drive(ch);

      if (cls == CLS_NONE) begin
        oc = OUT_BAD;
      end else if (cls == CLS_TF && rsel == TF_DATA) begin
        oc = OUT_UNIMPL;
      end else if (r.access_len != 3'd1) begin
        oc = OUT_BAD;
      end else if (cls == CLS_DMA) begin
        // bus-master bytes of the selected drive
        if (rsel[2:0] == DMA_RSV1 || rsel[2:0] == DMA_RSV3) begin
          oc = OUT_BAD;
        end else if (r.op == OP_WRITE) begin
          case (rsel[2:0])
            DMA_CMD: dcmd[d] = wb;
            DMA_STAT: dstat[d] = wb;
            default: prd[d][rsel[1:0]*8 +: 8] = wb;
          endcase
        end else begin
          case (rsel[2:0])
            DMA_CMD: rb = dcmd[d];
            DMA_STAT: rb = dstat[d];
            default: rb = prd[d][rsel[1:0]*8 +: 8];
          endcase
        end
      end else if (r.op == OP_WRITE) begin
        case (rsel)
          TF_FEAT: ;
          TF_SCNT: scnt[d] = wb;
          TF_SNUM: snum[d] = wb;
          TF_CYLL: cyl[d][7:0] = wb;
          TF_CYLH: cyl[d][15:8] = wb;
          TF_DRVHD: begin
            drvhd[ch] = wb | DRVHD_FIXED;
            if (absent(sel_drive(ch))) begin
              err[ch] = err[ch] | ERR_ABORT;
              stat[ch] = stat[ch] | STAT_ERR;
            end
          end
          TF_CMD: begin
            if (wb == CMD_PACKET) begin
              if (kind[d] != KIND_CDROM) irq = abort_cmd(ch);
              scnt[d] = SECT_RESET;
              stat[ch] = (stat[ch] & ~STAT_BSY_DF_ERR) | STAT_DRQ;
            end else if (wb == CMD_ID_PKT) begin
              err[ch] = '0;
              stat[ch] = STAT_ID_PKT;
              irq = !ctrl[ch][NIEN_BIT];
            end else if (wb == CMD_IDENTIFY && kind[d] != KIND_DISK) begin
              reset_drive(d);
              irq = abort_cmd(ch);
            end else begin
              oc = OUT_UNIMPL;
            end
          end
          TF_CTRL: begin
            // soft reset on both edges of srst
            if (!ctrl[ch][SRST_BIT] && wb[SRST_BIT]) begin
              stat[ch] = STAT_SRST;
              err[ch] = ERR_DIAG_OK;
            end else if (ctrl[ch][SRST_BIT] && !wb[SRST_BIT]) begin
              stat[ch] = (stat[ch] & STAT_NOT_BSY) | STAT_DRDY;
              drvhd[ch] = drvhd[ch] & DRVHD_NO_HEAD;
              reset_drive({ch, 1'b0});
              reset_drive({ch, 1'b1});
            end
            ctrl[ch] = wb;
          end
          default: oc = OUT_BAD;
        endcase
      end else begin
        // task file read, an absent drive floats everything but the address and drive/head registers
        if (rsel == TF_ADDR) begin
          rb = ADDR_READ;
        end else if (absent(d)) begin
          rb = (rsel == TF_DRVHD) ? DRVHD_FIXED : 8'h00;
        end else begin
          case (rsel)
            TF_FEAT: rb = err[ch];
            TF_SCNT: rb = scnt[d];
            TF_SNUM: rb = snum[d];
            TF_CYLL: rb = cyl[d][7:0];
            TF_CYLH: rb = cyl[d][15:8];
            TF_DRVHD: rb = drvhd[ch];
            default: rb = stat[ch];
          endcase
        end
      end

      e.read_byte = (r.op == OP_WRITE) ? 8'h00 : rb;
      e.outcome = oc;
      e.irq_pulse = irq;
      e.irq_chan = irq ? ch : 1'b0;
      expected_replies.push_back(e);
    endfunction

    function void check_reply(rsp_t a);
      rsp_t e;
      if (expected_replies.size() == 0) begin
        $display("%0t: reply with no request pending: %h", $time, a);
        mismatches++;
        return;
      end
      e = expected_replies.pop_front();
      if (a.read_byte !== e.read_byte) begin
        $display("%0t: read_byte expected %02h, got %02h", $time, e.read_byte, a.read_byte);
        mismatches++;
      end
      if (a.outcome !== e.outcome) begin
        $display("%0t: outcome expected %0d, got %0d", $time, e.outcome, a.outcome);
        mismatches++;
      end
      if (a.irq_pulse !== e.irq_pulse) begin
        $display("%0t: irq_pulse expected %b, got %b", $time, e.irq_pulse, a.irq_pulse);
        mismatches++;
      end
      if (a.irq_chan !== e.irq_chan) begin
        $display("%0t: irq_chan expected %b, got %b", $time, e.irq_chan, a.irq_chan);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit calm;
  int stall_left;
  int idle_cycles;
  task_file_shadow shadow;

  atf_req_if req_bus ();
  atf_rsp_if rsp_bus ();
  atf_cfg_if cfg_bus ();

  ata_task_file_registers dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus),
    .cfg (cfg_bus)
  );

  always #1 clk = ~clk;

  // mostly short gaps, a few long ones, none during calm stretches
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // reply side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      rsp_bus.ready <= 1'b0;
      stall_left--;
    end else begin
      rsp_bus.ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // reply checking
  always @(posedge clk) begin
    if (!rst && rsp_bus.valid && rsp_bus.ready)
      shadow.check_reply(rsp_t'({rsp_bus.read_byte, rsp_bus.outcome, rsp_bus.irq_pulse,
                                 rsp_bus.irq_chan}));
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("tb_ata_task_file_registers: FAIL");
        $finish;
      end
    end
  end

  task send_access(input req_t r);
    req_bus.op <= r.op;
    req_bus.port_addr <= r.port_addr;
    req_bus.access_len <= r.access_len;
    req_bus.write_byte <= r.write_byte;
    req_bus.valid <= 1'b1;
    do @(posedge clk); while (!req_bus.ready);
    shadow.note_access(r);
  endtask

  task access(input logic op, input logic [15:0] port, input logic [2:0] len,
              input logic [7:0] wb);
    req_t r;
    int gap;
    r.op = op;
    r.port_addr = port;
    r.access_len = len;
    r.write_byte = wb;
    gap = pick_gap();
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    send_access(r);
  endtask

  // drain every outstanding request so the block is idle
  task settle();
    req_bus.valid <= 1'b0;
    while (shadow.expected_replies.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task set_kinds(input logic [KIND_W-1:0] k0, input logic [KIND_W-1:0] k1,
                 input logic [KIND_W-1:0] k2, input logic [KIND_W-1:0] k3);
    logic [KIND_W-1:0] ks[NUM_DRIVES];
    ks = '{k0, k1, k2, k3};
    for (int i = 0; i < NUM_DRIVES; i++) begin
      cfg_bus.index <= CFG_INDEX_W'(i);
      cfg_bus.data <= ks[i];
      cfg_bus.valid <= 1'b1;
      do @(posedge clk); while (!cfg_bus.ready);
      shadow.set_kind(i, ks[i]);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // biased towards well-formed single-byte accesses on known ports
  task random_access();
    int pick;
    logic ch;
    logic op;
    logic [15:0] port;
    logic [2:0] len;
    logic [7:0] wb;
    pick = $urandom_range(0, 99);
    ch = 1'($urandom_range(0, 1));
    op = 1'($urandom_range(0, 1));
    wb = 8'($urandom_range(0, 255));
    len = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd1;
    if (pick < 60) begin
      port = (ch ? BASE_SEC : BASE_PRI) | 16'($urandom_range(1, 7));
      if (port[2:0] == 3'd7) begin
        case ($urandom_range(0, 3))
          0: wb = CMD_PACKET;
          1: wb = CMD_ID_PKT;
          2: wb = CMD_IDENTIFY;
          default: ;
        endcase
      end
    end else if (pick < 72) begin
      port = (ch ? CTL_SEC : CTL_PRI) | 16'($urandom_range(0, 1));
      if ($urandom_range(0, 3) != 0) wb = 8'($urandom_range(0, 7));
    end else if (pick < 86) begin
      port = BASE_DMA | 16'($urandom_range(0, 15));
    end else if (pick < 90) begin
      port = ch ? BASE_SEC : BASE_PRI;
    end else if (pick < 95) begin
      port = (ch ? CTL_SEC : BASE_PRI) ^ (16'h0001 << $urandom_range(3, 15));
    end else begin
      port = 16'($urandom_range(0, 65535));
    end
    access(op, port, len, wb);
  endtask

  initial begin
    shadow = new();
    clk = 1'b0;
    rst = 1'b1;
    calm = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.op = OP_READ;
    req_bus.port_addr = '0;
    req_bus.access_len = '0;
    req_bus.write_byte = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    settle();

    // directed: primary disk and cdrom, secondary absent and out-of-range kind
    set_kinds(KIND_DISK, KIND_CDROM, KIND_NONE, 2'd3);
    access(OP_READ, 16'h01f7, 3'd1, 8'h00);
    access(OP_WRITE, 16'h01f0, 3'd4, 8'h5a);
    access(OP_READ, 16'h01f2, 3'd2, 8'h00);
    access(OP_READ, 16'h03f7, 3'd1, 8'h00);
    access(OP_WRITE, 16'h03f7, 3'd1, 8'h11);
    access(OP_READ, 16'hffff, 3'd1, 8'hff);
    access(OP_WRITE, 16'hc001, 3'd1, 8'hff);
    access(OP_WRITE, 16'hc007, 3'd1, 8'h80);
    access(OP_READ, 16'hc007, 3'd1, 8'h00);
    access(OP_WRITE, 16'hc002, 3'd1, 8'hff);
    access(OP_READ, 16'hc002, 3'd1, 8'h00);
    access(OP_WRITE, 16'h01f6, 3'd1, 8'h10);
    access(OP_WRITE, 16'h01f7, 3'd1, CMD_PACKET);
    access(OP_WRITE, 16'h01f7, 3'd1, CMD_IDENTIFY);
    access(OP_WRITE, 16'h01f6, 3'd1, 8'h0f);
    access(OP_WRITE, 16'h01f7, 3'd1, CMD_IDENTIFY);
    access(OP_WRITE, 16'h01f7, 3'd1, CMD_PACKET);
    access(OP_WRITE, 16'h03f6, 3'd1, 8'h04);
    access(OP_WRITE, 16'h03f6, 3'd1, 8'h02);
    access(OP_WRITE, 16'h01f7, 3'd1, CMD_ID_PKT);
    access(OP_READ, 16'h01f6, 3'd1, 8'h00);
    access(OP_WRITE, 16'h0176, 3'd1, 8'h00);
    access(OP_READ, 16'h0171, 3'd1, 8'h00);
    access(OP_WRITE, 16'h0177, 3'd1, 8'h00);
    access(OP_WRITE, 16'h01f3, 3'd1, 8'hff);
    access(OP_READ, 16'h01f3, 3'd1, 8'h00);

    // random phases, each under its own set of drive kinds
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      case (phase)
        0: set_kinds(KIND_CDROM, KIND_DISK, 2'd3, KIND_NONE);
        1: set_kinds(KIND_DISK, KIND_DISK, KIND_DISK, KIND_DISK);
        2: set_kinds(KIND_CDROM, KIND_CDROM, KIND_CDROM, KIND_CDROM);
        3: set_kinds(KIND_NONE, KIND_NONE, KIND_NONE, KIND_NONE);
        4: set_kinds(2'd3, 2'd3, 2'd3, 2'd3);
        default: set_kinds(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                           2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
        random_access();
      end
    end

    settle();
    if (shadow.mismatches == 0)
      $display("tb_ata_task_file_registers: PASS");
    else
      $display("tb_ata_task_file_registers: FAIL");
    $finish;
  end

endmodule
